// ===== rtl/slcc_pkg.sv =====
// Package for the static loop chunk calculator.
// Holds the register codes, sequencer states, the setup parameter bundle and the job record.
// No dependencies.
package slcc_pkg;

    localparam int MAX_THREADS = 256;
    localparam int P_W = $clog2(MAX_THREADS) + 1;

    typedef enum logic [2:0] {
        CFG_LOOP_START   = 3'd0,
        CFG_LOOP_BOUND   = 3'd1,
        CFG_LOOP_STEP    = 3'd2,
        CFG_CHUNK_LENGTH = 3'd3,
        CFG_THREAD_COUNT = 3'd4
    } slcc_cfg_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_KICK,
        SEQ_TRIP,
        SEQ_CS,
        SEQ_FULL,
        SEQ_FULLP,
        SEQ_DLEN,
        SEQ_TFROM,
        SEQ_TTO
    } slcc_seq_t;

    typedef enum logic [1:0] {
        LEN_LO,
        LEN_HI,
        LEN_TAIL
    } slcc_len_t;

    typedef struct packed {
        logic            busy;
        logic            err;
        logic            bal;
        logic [P_W-1:0]  p;
        logic            trip_nz;
        logic [31:0]     cs;
        logic [P_W-1:0]  rem;
        logic [30:0]     c;
        logic [31:0]     fullp;
        logic [P_W-1:0]  turn;
        logic            tail_nz;
        logic [31:0]     inc;
        logic [63:0]     lb;
        logic [63:0]     dlo;
        logic [63:0]     dhi;
        logic [63:0]     tail_from;
        logic [63:0]     tail_to;
    } slcc_params_t;

    typedef struct packed {
        logic [39:0]     m;
        logic [31:0]     g;
        logic [P_W-1:0]  add;
        slcc_len_t       len;
        logic            valid;
        logic            err;
        logic [32:0]     total;
    } slcc_job_t;

endpackage

// ===== rtl/slcc_div.sv =====
// Radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle.
// Uses no package.
module slcc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quot,
    output logic [31:0] rem
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] shifted;
    logic [33:0] sub;
    logic        ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[31]};
        sub       = {1'b0, shifted} - {2'b0, dvs_reg};
        ge        = !sub[33];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? sub[31:0] : shifted[31:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/slcc_setup.sv =====
// Configuration registers and the setup sequencer that derives per-loop constants.
// Depends on slcc_pkg and slcc_div.
module slcc_setup (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [2:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    output slcc_pkg::slcc_params_t  prm
);

    logic [31:0]         start_reg, bound_reg, step_reg;
    logic [30:0]         clen_reg;
    logic [8:0]          tcnt_reg;
    slcc_pkg::slcc_seq_t state_reg, state_next;

    logic [31:0] trip_reg, cs_reg, fullp_reg;
    logic [slcc_pkg::P_W-1:0] rem_reg, turn_reg;
    logic [30:0] tail_reg;
    logic [63:0] dlo_reg, dhi_reg, tfrom_reg, tto_reg;

    logic [63:0] lb64, inc64;
    logic [32:0] diff33, adiff33;
    logic [31:0] uinc;
    logic [slcc_pkg::P_W-1:0] p_eff;
    logic        bal;
    logic        div_start, div_done;
    logic [31:0] div_a, div_b, div_q, div_r;
    logic        r_nz;
    logic [31:0] trip_calc;
    logic [31:0] mul_a;
    logic signed [64:0] mul_p;
    logic [63:0] prod64;

    slcc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_comb
    begin
        lb64    = {{32{start_reg[31]}}, start_reg};
        inc64   = {{32{step_reg[31]}}, step_reg};
        diff33  = {bound_reg[31], bound_reg} - {start_reg[31], start_reg};
        adiff33 = diff33[32] ? (33'd0 - diff33) : diff33;
        uinc    = step_reg[31] ? (32'd0 - step_reg) : step_reg;
        bal     = (clen_reg == 31'd0);
        if (tcnt_reg == 9'd0)
            p_eff = slcc_pkg::P_W'(1);
        else if (tcnt_reg > 9'(slcc_pkg::MAX_THREADS))
            p_eff = slcc_pkg::P_W'(slcc_pkg::MAX_THREADS);
        else
            p_eff = slcc_pkg::P_W'(tcnt_reg);
        r_nz = (div_r != 32'd0);
        if (diff33[32] == step_reg[31])
            trip_calc = div_q + {31'd0, r_nz};
        else
            trip_calc = {31'd0, (div_q == 32'd0) && r_nz};
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_a      = '0;
        div_b      = '0;
        mul_a      = '0;
        case (state_reg)
            slcc_pkg::SEQ_KICK:
            begin
                div_start  = 1'b1;
                div_a      = adiff33[31:0];
                div_b      = uinc;
                state_next = slcc_pkg::SEQ_TRIP;
            end
            slcc_pkg::SEQ_TRIP:
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_a      = trip_calc;
                    div_b      = 32'(p_eff);
                    state_next = slcc_pkg::SEQ_CS;
                end
            slcc_pkg::SEQ_CS:
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_a      = trip_reg;
                    div_b      = {1'b0, clen_reg};
                    state_next = slcc_pkg::SEQ_FULL;
                end
            slcc_pkg::SEQ_FULL:
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_a      = div_q;
                    div_b      = 32'(p_eff);
                    state_next = slcc_pkg::SEQ_FULLP;
                end
            slcc_pkg::SEQ_FULLP:
                if (div_done)
                    state_next = slcc_pkg::SEQ_DLEN;
            slcc_pkg::SEQ_DLEN:
            begin
                mul_a      = bal ? cs_reg : {1'b0, clen_reg};
                state_next = slcc_pkg::SEQ_TFROM;
            end
            slcc_pkg::SEQ_TFROM:
            begin
                mul_a      = bal ? trip_reg : (trip_reg - {1'b0, tail_reg});
                state_next = slcc_pkg::SEQ_TTO;
            end
            slcc_pkg::SEQ_TTO:
            begin
                mul_a      = trip_reg;
                state_next = slcc_pkg::SEQ_IDLE;
            end
            default: ;
        endcase
        if (cfg_write)
            state_next = slcc_pkg::SEQ_KICK;
    end

    assign mul_p  = $signed({1'b0, mul_a}) * $signed(step_reg);
    assign prod64 = mul_p[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            bound_reg <= '0;
            step_reg  <= 32'd1;
            clen_reg  <= '0;
            tcnt_reg  <= 9'd1;
            state_reg <= slcc_pkg::SEQ_KICK;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    slcc_pkg::CFG_LOOP_START:   start_reg <= cfg_data;
                    slcc_pkg::CFG_LOOP_BOUND:   bound_reg <= cfg_data;
                    slcc_pkg::CFG_LOOP_STEP:    step_reg  <= cfg_data;
                    slcc_pkg::CFG_CHUNK_LENGTH: clen_reg  <= cfg_data[30:0];
                    slcc_pkg::CFG_THREAD_COUNT: tcnt_reg  <= cfg_data[8:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            slcc_pkg::SEQ_TRIP:
                if (div_done)
                    trip_reg <= trip_calc;
            slcc_pkg::SEQ_CS:
                if (div_done)
                begin
                    cs_reg  <= div_q;
                    rem_reg <= div_r[slcc_pkg::P_W-1:0];
                end
            slcc_pkg::SEQ_FULL:
                if (div_done)
                    tail_reg <= div_r[30:0];
            slcc_pkg::SEQ_FULLP:
                if (div_done)
                begin
                    fullp_reg <= div_q;
                    turn_reg  <= div_r[slcc_pkg::P_W-1:0];
                end
            slcc_pkg::SEQ_DLEN:
                dlo_reg <= prod64;
            slcc_pkg::SEQ_TFROM:
            begin
                tfrom_reg <= lb64 + prod64;
                dhi_reg   <= dlo_reg + inc64;
            end
            slcc_pkg::SEQ_TTO:
                tto_reg <= lb64 + prod64;
            default: ;
        endcase
    end

    always_comb
    begin
        prm.busy      = (state_reg != slcc_pkg::SEQ_IDLE);
        prm.err       = (step_reg == 32'd0);
        prm.bal       = bal;
        prm.p         = p_eff;
        prm.trip_nz   = (trip_reg != 32'd0);
        prm.cs        = cs_reg;
        prm.rem       = rem_reg;
        prm.c         = clen_reg;
        prm.fullp     = fullp_reg;
        prm.turn      = turn_reg;
        prm.tail_nz   = (tail_reg != 31'd0);
        prm.inc       = step_reg;
        prm.lb        = lb64;
        prm.dlo       = dlo_reg;
        prm.dhi       = dhi_reg;
        prm.tail_from = tfrom_reg;
        prm.tail_to   = tto_reg;
    end

endmodule

// ===== rtl/slcc_front.sv =====
// Request front end: classifies each request into a job and holds it in a two-entry queue.
// Depends on slcc_pkg.
module slcc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  slcc_pkg::slcc_params_t  prm,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [7:0]              thread_rank,
    input  logic [31:0]             chunk_index,
    input  logic                    pop,
    output logic                    head_valid,
    output slcc_pkg::slcc_job_t     head
);

    slcc_pkg::slcc_job_t slot_reg [2];
    logic                wr_reg, wr_next;
    logic                rd_reg, rd_next;
    logic [1:0]          count_reg, count_next;

    slcc_pkg::slcc_job_t job;
    logic [slcc_pkg::P_W-1:0] rank9;
    logic        live, has_tail, last, below_rem;
    logic [32:0] tot_chunk, total;
    logic [40:0] idxp;
    logic [39:0] m_chunk;
    logic        push, take;

    always_comb
    begin
        rank9     = slcc_pkg::P_W'(thread_rank);
        live      = prm.trip_nz && (rank9 < prm.p) && !prm.err;
        has_tail  = (rank9 == prm.turn) && prm.tail_nz;
        tot_chunk = {1'b0, prm.fullp} + {32'd0, rank9 < prm.turn} + {32'd0, has_tail};
        if (!live)
            total = '0;
        else if (prm.bal)
            total = 33'd1;
        else
            total = tot_chunk;
        last      = ({1'b0, chunk_index} == (total - 33'd1));
        idxp      = chunk_index * prm.p;
        m_chunk   = idxp[39:0] + {32'd0, thread_rank};
        below_rem = (rank9 < prm.rem);

        job.valid = ({1'b0, chunk_index} < total);
        job.err   = prm.err;
        job.total = total;
        if (prm.bal)
        begin
            job.m   = {32'd0, thread_rank};
            job.g   = prm.cs;
            job.add = below_rem ? rank9 : prm.rem;
            job.len = below_rem ? slcc_pkg::LEN_HI : slcc_pkg::LEN_LO;
        end
        else
        begin
            job.m   = m_chunk;
            job.g   = {1'b0, prm.c};
            job.add = '0;
            job.len = (has_tail && last) ? slcc_pkg::LEN_TAIL : slcc_pkg::LEN_LO;
        end
    end

    assign req_ready  = !prm.busy && (count_reg != 2'd2);
    assign push       = req_valid && req_ready;
    assign head_valid = (count_reg != 2'd0);
    assign take       = pop && head_valid;
    assign head       = slot_reg[rd_reg];

    always_comb
    begin
        wr_next    = push ? !wr_reg : wr_reg;
        rd_next    = take ? !rd_reg : rd_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= job;
    end

endmodule

// ===== rtl/slcc_back.sv =====
// Back end: five-stage multiply and add pipeline that turns a job into a chunk range.
// Depends on slcc_pkg.
module slcc_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  slcc_pkg::slcc_params_t  prm,
    input  logic                    head_valid,
    input  slcc_pkg::slcc_job_t     head,
    output logic                    pop,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic [63:0]             range_start,
    output logic [63:0]             range_end,
    output logic [32:0]             chunk_total,
    output logic                    chunk_valid,
    output logic                    step_error
);

    logic vb_reg, vc_reg, vd_reg, ve_reg, vf_reg;
    logic en;

    slcc_pkg::slcc_job_t job_b_reg, job_c_reg, job_d_reg, job_e_reg;
    logic [63:0] lo_b_reg;
    logic [31:0] hi_b_reg;
    logic [63:0] k_c_reg;
    logic [63:0] plo_d_reg;
    logic [31:0] phi_d_reg;
    logic [63:0] from_e_reg;
    logic [63:0] from_f_reg, to_f_reg;
    logic [32:0] total_f_reg;
    logic        valid_f_reg, err_f_reg;

    logic [63:0] lo_b_next;
    logic [39:0] hi_b_full;
    logic signed [64:0] plo_full;
    logic [63:0] phi_full;
    logic [63:0] to_len;

    assign en  = !(vf_reg && !rsp_ready);
    assign pop = en && head_valid;

    always_comb
    begin
        lo_b_next = head.m[31:0] * head.g;
        hi_b_full = head.m[39:32] * head.g;
        plo_full  = $signed({1'b0, k_c_reg[31:0]}) * $signed(prm.inc);
        phi_full  = k_c_reg[63:32] * prm.inc;
        to_len    = from_e_reg + ((job_e_reg.len == slcc_pkg::LEN_HI) ? prm.dhi : prm.dlo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            vb_reg <= head_valid;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            job_b_reg  <= head;
            lo_b_reg   <= lo_b_next;
            hi_b_reg   <= hi_b_full[31:0];

            job_c_reg  <= job_b_reg;
            k_c_reg    <= lo_b_reg + {hi_b_reg, 32'd0} + 64'(job_b_reg.add);

            job_d_reg  <= job_c_reg;
            plo_d_reg  <= plo_full[63:0];
            phi_d_reg  <= phi_full[31:0];

            job_e_reg  <= job_d_reg;
            from_e_reg <= prm.lb + plo_d_reg + {phi_d_reg, 32'd0};

            total_f_reg <= job_e_reg.total;
            valid_f_reg <= job_e_reg.valid;
            err_f_reg   <= job_e_reg.err;
            if (!job_e_reg.valid)
            begin
                from_f_reg <= '0;
                to_f_reg   <= '0;
            end
            else if (job_e_reg.len == slcc_pkg::LEN_TAIL)
            begin
                from_f_reg <= prm.tail_from;
                to_f_reg   <= prm.tail_to;
            end
            else
            begin
                from_f_reg <= from_e_reg;
                to_f_reg   <= to_len;
            end
        end
    end

    assign rsp_valid   = vf_reg;
    assign range_start = from_f_reg;
    assign range_end   = to_f_reg;
    assign chunk_total = total_f_reg;
    assign chunk_valid = valid_f_reg;
    assign step_error  = err_f_reg;

endmodule

// ===== rtl/static_loop_chunk_calculator.sv =====
// Top level of the static loop chunk calculator.
// Depends on slcc_pkg, slcc_setup, slcc_front and slcc_back.
//
// Returns the iteration range of one statically scheduled loop chunk per request. The block
// takes one request per cycle and delivers one result per cycle at full rate while rsp_ready
// stays high and setup is idle; a taken request is written into the two-entry front queue and
// then passes the multiply and add pipeline registers B to F. After reset and after every
// configuration write the setup sequencer derives the trip count and the per-thread split
// with one shared radix-2 divider, four divisions and three multiply steps, and req_ready
// stays low until it is done.
module static_loop_chunk_calculator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [7:0]  thread_rank,
    input  logic [31:0] chunk_index,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic signed [63:0] range_start,
    output logic signed [63:0] range_end,
    output logic [32:0] chunk_total,
    output logic        chunk_valid,
    output logic        step_error
);

    slcc_pkg::slcc_params_t prm;
    slcc_pkg::slcc_job_t    head;
    logic                   head_valid, pop;
    logic [63:0]            rs, re;

    assign cfg_ready = 1'b1;

    slcc_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .prm       (prm)
    );

    slcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .prm         (prm),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .thread_rank (thread_rank),
        .chunk_index (chunk_index),
        .pop         (pop),
        .head_valid  (head_valid),
        .head        (head)
    );

    slcc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .prm         (prm),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .range_start (rs),
        .range_end   (re),
        .chunk_total (chunk_total),
        .chunk_valid (chunk_valid),
        .step_error  (step_error)
    );

    assign range_start = $signed(rs);
    assign range_end   = $signed(re);

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && step_error |-> !chunk_valid && chunk_total == 33'd0)
        else $error("step error result carries a chunk");

    a_valid_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && chunk_valid |-> chunk_total != 33'd0 && !step_error)
        else $error("valid chunk with zero chunk total");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !chunk_valid |-> range_start == 64'sd0 && range_end == 64'sd0)
        else $error("invalid chunk with nonzero range");

    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        prm.busy |-> !req_ready)
        else $error("request taken while setup is running");

endmodule

// ===== sim/tb.sv =====
// Testbench for static_loop_chunk_calculator: directed table, then randomized config phases.
// Every response beat is checked against a built-in chunk range predictor or, for typed rows, the table result.
// Depends on rtl/slcc_pkg.sv and rtl/static_loop_chunk_calculator.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] rstart;
        logic [63:0] rend;
        logic [32:0] total;
        logic        valid;
        logic        err;
    } chunk_res_t;

    typedef struct {
        logic [31:0] start;
        logic [31:0] bound;
        logic [31:0] step;
        logic [31:0] clen;
        logic [31:0] tcount;
        logic [7:0]  rank;
        logic [31:0] idx;
        bit          typed;
        chunk_res_t  res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        req_valid;
    logic        req_ready;
    logic [7:0]  thread_rank;
    logic [31:0] chunk_index;
    logic        rsp_valid;
    logic        rsp_ready;
    logic signed [63:0] range_start;
    logic signed [63:0] range_end;
    logic [32:0] chunk_total;
    logic        chunk_valid;
    logic        step_error;

    logic [31:0] sh_start, sh_bound, sh_step;
    logic [30:0] sh_clen;
    logic [8:0]  sh_tcount;

    chunk_res_t  chunk_q[$];
    int          mismatches;
    int          req_sent;
    int          idle_cycles;
    int          burst_left;
    int          stall_mode;
    int          stall_cnt;

    static_loop_chunk_calculator i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic chunk_res_t predict_chunk(logic [7:0] rank, logic [31:0] idx);
        longint      lb, bnd, inc, diff, q;
        logic [63:0] p, c, trip, total, from, to, full, tail, turn, cs, rem, first, ulb, uinc;
        logic [63:0] r64, i64;
        bit          has_tail;
        chunk_res_t  r;
        r = '0;
        lb = $signed(sh_start);
        bnd = $signed(sh_bound);
        inc = $signed(sh_step);
        if (inc == 0)
        begin
            r.err = 1'b1;
            return r;
        end
        p = sh_tcount;
        if (p == 0) p = 1;
        if (p > slcc_pkg::MAX_THREADS) p = slcc_pkg::MAX_THREADS;
        c = sh_clen;
        r64 = rank;
        i64 = idx;
        ulb = lb;
        uinc = inc;
        total = 0;
        from = 0;
        to = 0;
        diff = bnd - lb;
        q = diff / inc;
        if (diff % inc != 0) q++;
        trip = (q > 0) ? q : 0;
        if (trip > 0 && r64 < p)
        begin
            if (c == 0)
            begin
                cs = trip / p;
                rem = trip % p;
                total = 1;
                if (r64 < rem)
                begin
                    first = r64 * (cs + 1);
                    from = ulb + first * uinc;
                    to = from + (cs + 1) * uinc;
                end
                else
                begin
                    first = rem * (cs + 1) + (r64 - rem) * cs;
                    from = ulb + first * uinc;
                    to = from + cs * uinc;
                end
            end
            else
            begin
                full = trip / c;
                tail = trip % c;
                turn = full % p;
                has_tail = (r64 == turn) && tail != 0;
                total = full / p + (r64 < turn ? 1 : 0) + (has_tail ? 1 : 0);
                if (has_tail && i64 == total - 1)
                begin
                    from = ulb + full * c * uinc;
                    to = ulb + trip * uinc;
                end
                else
                begin
                    from = ulb + (i64 * p + r64) * c * uinc;
                    to = from + c * uinc;
                end
            end
        end
        r.valid = i64 < total;
        r.rstart = r.valid ? from : 64'd0;
        r.rend = r.valid ? to : 64'd0;
        r.total = total[32:0];
        return r;
    endfunction

    // writes the registers selected by mask back to back, valid held across beats
    task automatic write_regs(logic [31:0] v [5], logic [4:0] mask);
        slcc_pkg::slcc_cfg_t reg_id;
        for (int k = 0; k < 5; k++)
        begin
            if (mask[k])
            begin
                reg_id = slcc_pkg::slcc_cfg_t'(k);
                cfg_valid <= 1'b1;
                cfg_index <= reg_id;
                cfg_data <= v[k];
                do @(posedge clk); while (!cfg_ready);
                case (reg_id)
                    slcc_pkg::CFG_LOOP_START:   sh_start = v[k];
                    slcc_pkg::CFG_LOOP_BOUND:   sh_bound = v[k];
                    slcc_pkg::CFG_LOOP_STEP:    sh_step = v[k];
                    slcc_pkg::CFG_CHUNK_LENGTH: sh_clen = v[k][30:0];
                    slcc_pkg::CFG_THREAD_COUNT: sh_tcount = v[k][8:0];
                    default: ;
                endcase
            end
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (chunk_q.size() != 0) @(posedge clk);
    endtask

    task automatic send_req(logic [7:0] rank, logic [31:0] idx, bit typed, chunk_res_t res);
        req_valid <= 1'b1;
        thread_rank <= rank;
        chunk_index <= idx;
        do @(posedge clk); while (!req_ready);
        chunk_q.push_back(typed ? res : predict_chunk(rank, idx));
        req_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic set_cfg(logic [31:0] v [5]);
        logic [4:0] mask;
        mask[slcc_pkg::CFG_LOOP_START]   = v[0] != sh_start;
        mask[slcc_pkg::CFG_LOOP_BOUND]   = v[1] != sh_bound;
        mask[slcc_pkg::CFG_LOOP_STEP]    = v[2] != sh_step;
        mask[slcc_pkg::CFG_CHUNK_LENGTH] = v[3] != {1'b0, sh_clen};
        mask[slcc_pkg::CFG_THREAD_COUNT] = v[4] != {23'd0, sh_tcount};
        if (mask != 0)
        begin
            drain();
            write_regs(v, mask);
        end
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 200) - 100;
        endcase
    endfunction

    stim_row_t table_rows[] = '{
        '{0, 0, 1, 0, 1, 8'd0, 32'd0, 1, '0},
        '{0, 0, 1, 0, 1, 8'd255, 32'hFFFF_FFFF, 1, '0},
        '{0, 10, 0, 0, 1, 8'd0, 32'd0, 1, '{0, 0, 0, 0, 1}},
        '{0, 10, 0, 0, 1, 8'd255, 32'hFFFF_FFFF, 1, '{0, 0, 0, 0, 1}},
        '{0, 10, 1, 0, 4, 8'd0, 32'd0, 0, '0},
        '{0, 10, 1, 0, 4, 8'd1, 32'd0, 0, '0},
        '{0, 10, 1, 0, 4, 8'd3, 32'd0, 0, '0},
        '{0, 10, 1, 0, 4, 8'd4, 32'd0, 1, '0},
        '{0, 10, 1, 0, 4, 8'd0, 32'd1, 0, '0},
        '{0, 10, 1, 3, 4, 8'd0, 32'd0, 0, '0},
        '{0, 10, 1, 3, 4, 8'd0, 32'd1, 0, '0},
        '{0, 10, 1, 3, 4, 8'd3, 32'd0, 0, '0},
        '{0, 10, 1, 3, 4, 8'd2, 32'd0, 0, '0},
        '{10, -5, -3, 2, 2, 8'd0, 32'd0, 0, '0},
        '{10, -5, -3, 2, 2, 8'd1, 32'd2, 0, '0},
        '{5, 5, 1, 0, 2, 8'd0, 32'd0, 1, '0},
        '{0, 7, 1, 0, 0, 8'd0, 32'd0, 0, '0},
        '{0, 7, 1, 0, 0, 8'd1, 32'd0, 1, '0},
        '{0, 7, 1, 0, 511, 8'd255, 32'd0, 0, '0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 256, 8'd255, 32'd0, 0, '0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, 8'd0, 32'd1, 0, '0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1, 3, 8'd0, 32'd0, 0, '0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1, 3, 8'd1, 32'd0, 0, '0}
    };

    initial
    begin
        logic [31:0] v [5];
        logic [7:0]  rank;
        logic [31:0] idx;
        chunk_res_t  probe;
        logic [32:0] tot;
        int          n_items;
        cfg_valid = 1'b0;
        cfg_index = slcc_pkg::CFG_LOOP_START;
        cfg_data = '0;
        req_valid = 1'b0;
        thread_rank = '0;
        chunk_index = '0;
        rst_n = 1'b0;
        sh_start = 0;
        sh_bound = 0;
        sh_step = 1;
        sh_clen = 0;
        sh_tcount = 1;
        mismatches = 0;
        req_sent = 0;
        burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        v = '{32'd7, 32'd3, 32'd2, 32'd5, 32'd2};
        write_regs(v, 5'b11111);
        foreach (table_rows[i])
        begin
            v = '{table_rows[i].start, table_rows[i].bound, table_rows[i].step,
                  table_rows[i].clen, table_rows[i].tcount};
            set_cfg(v);
            send_req(table_rows[i].rank, table_rows[i].idx, table_rows[i].typed,
                     table_rows[i].res);
        end

        while (req_sent < 1500)
        begin
            v[0] = rand_pos();
            v[1] = rand_pos();
            case ($urandom_range(0, 11))
                0: v[2] = 0;
                1: v[2] = 32'h8000_0000;
                2: v[2] = 32'h7FFF_FFFF;
                3: v[2] = $urandom;
                default: v[2] = $urandom_range(0, 16) - 8;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: v[3] = 0;
                3: v[3] = $urandom;
                4: v[3] = 32'h7FFF_FFFF;
                default: v[3] = $urandom_range(1, 10);
            endcase
            case ($urandom_range(0, 11))
                0: v[4] = 0;
                1: v[4] = 256;
                2: v[4] = $urandom_range(257, 511);
                3: v[4] = $urandom;
                default: v[4] = $urandom_range(1, 16);
            endcase
            drain();
            write_regs(v, $urandom_range(0, 3) == 0 ? 5'b11111 : 5'($urandom));
            n_items = $urandom_range(30, 120);
            for (int k = 0; k < n_items; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    rank = $urandom;
                else
                    rank = $urandom_range(0, (sh_tcount == 0) ? 0 :
                                             (sh_tcount > 256) ? 255 : sh_tcount - 1);
                probe = predict_chunk(rank, 32'd0);
                tot = probe.total;
                case ($urandom_range(0, 9))
                    0: idx = $urandom;
                    1: idx = (tot > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : tot[31:0];
                    default: idx = (tot == 0) ? 32'd0 :
                        (tot > 33'hFFFF_FFFF) ? $urandom : $urandom_range(0, tot - 1);
                endcase
                send_req(rank, idx, 1'b0, '0);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        chunk_res_t e;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_mode <= 0;
            stall_cnt <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (chunk_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response beat");
                end
                else
                begin
                    e = chunk_q.pop_front();
                    if (range_start !== e.rstart || range_end !== e.rend ||
                        chunk_total !== e.total || chunk_valid !== e.valid ||
                        step_error !== e.err)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %h %h %h %b %b got %h %h %h %b %b",
                                     e.rstart, e.rend, e.total, e.valid, e.err,
                                     range_start, range_end, chunk_total, chunk_valid,
                                     step_error);
                    end
                end
            end
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt % 64 == 63)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= $urandom_range(0, 1);
                2: rsp_ready <= (stall_cnt % 4 == 0);
                default: rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (req_valid && req_ready) ||
            (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/slcc_pkg.sv
rtl/slcc_div.sv
rtl/slcc_setup.sv
rtl/slcc_front.sv
rtl/slcc_back.sv
rtl/static_loop_chunk_calculator.sv
sim/tb.sv
